// ----- src/pmfb_pkg.sv -----
// shared types and constants for the page-organized monochrome framebuffer
// no dependencies; used by pmfb_front, pmfb_back and the top level
`timescale 1ns / 1ps
`default_nettype none

package pmfb_pkg;

	// action codes on the input channel
	localparam logic [1:0] ACT_SET   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 1'b1;

	// field-driven widths
	localparam int PANEL_W_W   = 8;
	localparam int PANEL_H_W   = 7;
	localparam int PAGES_W     = 4;
	localparam int ADDR_RAW_W  = 11;  // x + page*width, at most 1912
	localparam int CALC_MIN_W  = 12;  // width*pages, at most 3825
	localparam int PIX_BITS    = 8;
	localparam int BIT_SEL_W   = 3;

	// status codes
	localparam logic STAT_DONE   = 1'b0;
	localparam logic STAT_REJECT = 1'b1;

	typedef enum logic [1:0] {
		CMD_SET,
		CMD_CLEAR,
		CMD_READ,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [BIT_SEL_W-1:0]   bit_sel;
		logic                   pix_on;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_MODIFY,
		ST_READ,
		ST_CLEAR
	} back_state_t;

endpackage

`default_nettype wire

// ----- src/pmfb_ram.sv -----
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pmfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- src/pmfb_queue.sv -----
// short fifo carrying classified commands from front to back
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pmfb_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("command queue underflow");

endmodule

`default_nettype wire

// ----- src/pmfb_front.sv -----
// front end: accepts actions, range-checks them and computes byte addresses
// depends on pmfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module pmfb_front #(
	parameter int STORE_BYTES = 1024,
	parameter int CALC_W      = 12
) (
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       action,
	input  wire logic [6:0]                       pix_x,
	input  wire logic [5:0]                       pix_y,
	input  wire logic                             pix_on,
	input  wire logic [9:0]                       byte_index,
	input  wire logic [pmfb_pkg::PANEL_W_W-1:0]   panel_width,
	input  wire logic [pmfb_pkg::PANEL_H_W-1:0]   panel_height,
	input  wire logic                             init_busy,
	input  wire logic                             q_full,
	output logic                                  push,
	output pmfb_pkg::cmd_t                        cmd,
	output logic      [CALC_W-1:0]                cmd_addr
);

	localparam logic [CALC_W-1:0] STORE_LIM = CALC_W'(STORE_BYTES);

	logic [pmfb_pkg::PAGES_W-1:0]    pages;
	logic [2:0]                      page_y;
	logic [pmfb_pkg::CALC_MIN_W-1:0] used_raw;
	logic [CALC_W-1:0]               used;
	logic [pmfb_pkg::ADDR_RAW_W-1:0] addr_raw;
	logic                            set_ok;

	assign in_ready = !q_full && !init_busy;
	assign push     = in_valid && in_ready;

	assign pages  = panel_height[pmfb_pkg::PANEL_H_W-1:3];
	assign page_y = pix_y[5:3];

	// used byte count, capped at the store size
	assign used_raw = pmfb_pkg::CALC_MIN_W'(panel_width) * pmfb_pkg::CALC_MIN_W'(pages);
	assign used     = (CALC_W'(used_raw) > STORE_LIM) ? STORE_LIM : CALC_W'(used_raw);

	assign addr_raw = pmfb_pkg::ADDR_RAW_W'(pix_x)
		+ pmfb_pkg::ADDR_RAW_W'(page_y) * pmfb_pkg::ADDR_RAW_W'(panel_width);

	// partial last page rows count as outside the panel
	assign set_ok = (pmfb_pkg::PANEL_W_W'(pix_x) < panel_width)
		&& (pmfb_pkg::PAGES_W'(page_y) < pages)
		&& (CALC_W'(addr_raw) < STORE_LIM);

	always_comb begin
		cmd.bit_sel = pix_y[2:0];
		cmd.pix_on  = pix_on;
		cmd.kind    = pmfb_pkg::CMD_REJECT;
		cmd_addr    = CALC_W'(byte_index);
		unique case (action)
			pmfb_pkg::ACT_SET: begin
				cmd.kind = set_ok ? pmfb_pkg::CMD_SET : pmfb_pkg::CMD_REJECT;
				cmd_addr = CALC_W'(addr_raw);
			end
			pmfb_pkg::ACT_CLEAR: begin
				cmd.kind = pmfb_pkg::CMD_CLEAR;
				cmd_addr = used;
			end
			pmfb_pkg::ACT_READ: begin
				cmd.kind = (CALC_W'(byte_index) < used) ? pmfb_pkg::CMD_READ
					: pmfb_pkg::CMD_REJECT;
			end
			default: begin
				cmd.kind = pmfb_pkg::CMD_REJECT;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/pmfb_back.sv -----
// back end: sequencer over the frame ram, result register, power-up clear
// depends on pmfb_pkg and pmfb_ram
`timescale 1ns / 1ps
`default_nettype none

module pmfb_back #(
	parameter int STORE_BYTES = 1024,
	parameter int CALC_W      = 12
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cmd_valid,
	input  wire pmfb_pkg::cmd_t                     cmd,
	input  wire logic [CALC_W-1:0]                  cmd_addr,
	output logic                                    cmd_pop,
	output logic                                    init_busy,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [pmfb_pkg::PIX_BITS-1:0]      read_data,
	output logic                                    status
);

	localparam int AW = $clog2(STORE_BYTES);

	pmfb_pkg::back_state_t state_q, state_d;

	pmfb_pkg::cmd_t               cur_q;
	logic [CALC_W-1:0]            cur_addr_q;
	logic [AW-1:0]                ptr_q;
	logic                         out_valid_q;
	logic [pmfb_pkg::PIX_BITS-1:0] read_data_q;
	logic                         status_q;

	logic                          out_free;
	logic                          init_last;
	logic                          clear_last;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [pmfb_pkg::PIX_BITS-1:0] ram_wdata;
	logic [AW-1:0]                 ram_raddr;
	logic [pmfb_pkg::PIX_BITS-1:0] ram_rdata;
	logic [pmfb_pkg::PIX_BITS-1:0] bit_mask;
	logic                          load_res;
	logic [pmfb_pkg::PIX_BITS-1:0] res_data;
	logic                          res_status;

	pmfb_ram #(
		.WIDTH(pmfb_pkg::PIX_BITS),
		.DEPTH(STORE_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free   = !out_valid_q || out_ready;
	assign init_last  = (ptr_q == AW'(STORE_BYTES - 1));
	assign clear_last = ((CALC_W'(ptr_q) + 1'b1) == cur_addr_q);
	assign bit_mask   = pmfb_pkg::PIX_BITS'(1) << cur_q.bit_sel;
	assign init_busy  = (state_q == pmfb_pkg::ST_INIT);
	assign ram_raddr  = cmd_addr[AW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pmfb_pkg::ST_INIT: begin
				if (init_last) begin
					state_d = pmfb_pkg::ST_IDLE;
				end
			end
			pmfb_pkg::ST_IDLE: begin
				if (cmd_pop) begin
					unique case (cmd.kind)
						pmfb_pkg::CMD_SET:    state_d = pmfb_pkg::ST_MODIFY;
						pmfb_pkg::CMD_READ:   state_d = pmfb_pkg::ST_READ;
						pmfb_pkg::CMD_CLEAR:  state_d = (cmd_addr != '0)
							? pmfb_pkg::ST_CLEAR : pmfb_pkg::ST_IDLE;
						pmfb_pkg::CMD_REJECT: state_d = pmfb_pkg::ST_IDLE;
						default:              state_d = pmfb_pkg::ST_IDLE;
					endcase
				end
			end
			pmfb_pkg::ST_MODIFY: state_d = pmfb_pkg::ST_IDLE;
			pmfb_pkg::ST_READ:   state_d = pmfb_pkg::ST_IDLE;
			pmfb_pkg::ST_CLEAR: begin
				if (clear_last) begin
					state_d = pmfb_pkg::ST_IDLE;
				end
			end
			default: state_d = pmfb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop    = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = ptr_q;
		ram_wdata  = '0;
		load_res   = 1'b0;
		res_data   = '0;
		res_status = pmfb_pkg::STAT_DONE;
		unique case (state_q)
			pmfb_pkg::ST_INIT: begin
				ram_we = 1'b1;
			end
			pmfb_pkg::ST_IDLE: begin
				cmd_pop = cmd_valid && out_free;
				if (cmd_pop && cmd.kind == pmfb_pkg::CMD_REJECT) begin
					load_res   = 1'b1;
					res_status = pmfb_pkg::STAT_REJECT;
				end
				// clear over an empty panel finishes at once
				if (cmd_pop && cmd.kind == pmfb_pkg::CMD_CLEAR && cmd_addr == '0) begin
					load_res = 1'b1;
				end
			end
			pmfb_pkg::ST_MODIFY: begin
				ram_we    = 1'b1;
				ram_waddr = cur_addr_q[AW-1:0];
				ram_wdata = cur_q.pix_on ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
				load_res  = 1'b1;
			end
			pmfb_pkg::ST_READ: begin
				load_res = 1'b1;
				res_data = ram_rdata;
			end
			pmfb_pkg::ST_CLEAR: begin
				ram_we   = 1'b1;
				load_res = clear_last;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pmfb_pkg::ST_INIT;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pmfb_pkg::ST_INIT || state_q == pmfb_pkg::ST_CLEAR) begin
				ptr_q <= (state_d == pmfb_pkg::ST_IDLE) ? '0 : ptr_q + 1'b1;
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q      <= cmd;
			cur_addr_q <= cmd_addr;
		end
		if (load_res) begin
			read_data_q <= res_data;
			status_q    <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign status    = status_q;

	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == pmfb_pkg::ST_INIT || state_q == pmfb_pkg::ST_MODIFY
			|| state_q == pmfb_pkg::ST_CLEAR))
		else $error("frame ram written outside a write state");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |-> !out_valid_q || out_ready)
		else $error("result overwritten before transfer");

	a_access_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pmfb_pkg::ST_MODIFY || state_q == pmfb_pkg::ST_READ)
			|=> state_q == pmfb_pkg::ST_IDLE)
		else $error("ram access state did not return to idle");

	a_no_pop_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !cmd_pop)
		else $error("command taken during power-up clear");

endmodule

`default_nettype wire

// ----- src/page_mono_framebuffer_unit.sv -----
// top level of the page-organized monochrome framebuffer
// depends on pmfb_pkg, pmfb_front, pmfb_queue, pmfb_back (and pmfb_ram below it)
// a clear writes the frame ram over the panel's used bytes (one ram write per byte)
// set pixel is a read-modify-write on the single frame ram write port; the back end
//   takes no new command while a set, read or clear is still in progress
// reset: asynchronous, active low; afterwards the frame ram is zeroed in a sweep over
//   all STORE_BYTES bytes during which in_ready stays low (configuration writes still taken)
`timescale 1ns / 1ps
`default_nettype none

module page_mono_framebuffer_unit #(
	parameter int STORE_BYTES = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pmfb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pmfb_pkg::PANEL_W_W-1:0]      cfg_data,
	// action channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          action,
	input  wire logic [6:0]                          pix_x,
	input  wire logic [5:0]                          pix_y,
	input  wire logic                                pix_on,
	input  wire logic [9:0]                          byte_index,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [pmfb_pkg::PIX_BITS-1:0]       read_data,
	output logic                                     status
);

	// wide enough for the capped byte count, the store size and all field-driven sums
	localparam int CALC_W = ($clog2(STORE_BYTES) + 1 > pmfb_pkg::CALC_MIN_W)
		? $clog2(STORE_BYTES) + 1 : pmfb_pkg::CALC_MIN_W;
	localparam int Q_W    = $bits(pmfb_pkg::cmd_t) + CALC_W;

	logic [pmfb_pkg::PANEL_W_W-1:0] panel_width_q;
	logic [pmfb_pkg::PANEL_H_W-1:0] panel_height_q;

	// front to queue
	logic              push;
	pmfb_pkg::cmd_t    f_cmd;
	logic [CALC_W-1:0] f_addr;
	logic              q_full;

	// queue to back
	logic              q_not_empty;
	logic              q_pop;
	logic [Q_W-1:0]    q_data;
	pmfb_pkg::cmd_t    b_cmd;
	logic [CALC_W-1:0] b_addr;

	logic              init_busy;

	// configuration registers; a write is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q  <= pmfb_pkg::PANEL_W_W'(128);
			panel_height_q <= pmfb_pkg::PANEL_H_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pmfb_pkg::REG_PANEL_WIDTH:  panel_width_q  <= cfg_data;
				pmfb_pkg::REG_PANEL_HEIGHT: panel_height_q <= cfg_data[pmfb_pkg::PANEL_H_W-1:0];
				default:                    panel_width_q  <= panel_width_q;
			endcase
		end
	end

	// front: range check and address math; one transfer per cycle while in_ready is high
	pmfb_front #(
		.STORE_BYTES(STORE_BYTES),
		.CALC_W     (CALC_W)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.pix_x       (pix_x),
		.pix_y       (pix_y),
		.pix_on      (pix_on),
		.byte_index  (byte_index),
		.panel_width (panel_width_q),
		.panel_height(panel_height_q),
		.init_busy   (init_busy),
		.q_full      (q_full),
		.push        (push),
		.cmd         (f_cmd),
		.cmd_addr    (f_addr)
	);

	// two-entry queue decouples input stalls from long clear sweeps
	pmfb_queue #(
		.WIDTH(Q_W),
		.DEPTH(2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({f_cmd, f_addr}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_data),
		.not_empty(q_not_empty)
	);

	assign b_cmd  = pmfb_pkg::cmd_t'(q_data[Q_W-1:CALC_W]);
	assign b_addr = q_data[CALC_W-1:0];

	// back: ram sequencer and output register
	pmfb_back #(
		.STORE_BYTES(STORE_BYTES),
		.CALC_W     (CALC_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_not_empty),
		.cmd      (b_cmd),
		.cmd_addr (b_addr),
		.cmd_pop  (q_pop),
		.init_busy(init_busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.status   (status)
	);

endmodule

`default_nettype wire

// ----- tb/tb_page_mono_framebuffer_unit.sv -----
// self-checking testbench for page_mono_framebuffer_unit, the one-bit-per-pixel paged framebuffer
// depends on pmfb_pkg and the rtl top level; a built-in framebuffer predictor checks results
// not typed in; directed table first, then randomized action phases under several panel sizes
`timescale 1ns / 1ps

module tb_page_mono_framebuffer_unit;

	localparam int STORE_BYTES     = 1024;
	localparam int PAGE_ROWS       = 8;
	localparam int IDLE_PERCENT    = 16;
	localparam int HOLD_OFF_CYCLES = 400;   // long receiver hold-off to back the block up
	localparam int DRAIN_GAP       = 8;     // quiet cycles before a panel size change
	localparam int SETTLE_CYCLES   = 16;    // watch for stray results at the end
	localparam int END_WAIT_LIMIT  = 20000;
	localparam int TIMEOUT_NS      = 2_000_000;
	localparam int REPORT_LIMIT    = 10;

	// action, status and register codes as the block defines them
	localparam logic [1:0] ACT_SET   = pmfb_pkg::ACT_SET;
	localparam logic [1:0] ACT_CLEAR = pmfb_pkg::ACT_CLEAR;
	localparam logic [1:0] ACT_READ  = pmfb_pkg::ACT_READ;
	localparam logic STAT_DONE   = pmfb_pkg::STAT_DONE;
	localparam logic STAT_REJECT = pmfb_pkg::STAT_REJECT;
	localparam logic [pmfb_pkg::CFG_IDX_W-1:0] REG_PANEL_WIDTH  = pmfb_pkg::REG_PANEL_WIDTH;
	localparam logic [pmfb_pkg::CFG_IDX_W-1:0] REG_PANEL_HEIGHT = pmfb_pkg::REG_PANEL_HEIGHT;

	// the one action code the package leaves unnamed
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] read_data;
		logic       status;
	} panel_result_t;

	typedef enum logic {
		ROW_ACTION,
		ROW_PANEL
	} row_kind_t;

	// one line of the directed table; a panel row writes both size registers
	typedef struct packed {
		row_kind_t  kind;
		logic [7:0] width_data;
		logic [7:0] height_data;
		logic [1:0] act;
		logic [6:0] x;
		logic [5:0] y;
		logic       on;
		logic [9:0] idx;
		logic       known;       // expected result typed in below
		logic [7:0] exp_data;
		logic       exp_status;
	} bench_row_t;

	localparam int DIRECTED_ROWS = 31;

	// starts at the reset size of 128 x 64
	localparam bench_row_t DIRECTED [DIRECTED_ROWS] = '{
		// freshly swept store reads back zero at both ends
		'{ROW_ACTION, 8'd0, 8'd0, ACT_READ, 7'd0, 6'd0, 1'b0, 10'd0, 1'b1, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_READ, 7'd0, 6'd0, 1'b0, 10'd1023, 1'b1, 8'h00, STAT_DONE},
		// far corner pixel lands in the top bit of the last byte
		'{ROW_ACTION, 8'd0, 8'd0, ACT_SET, 7'd127, 6'd63, 1'b1, 10'd0, 1'b1, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_READ, 7'd0, 6'd0, 1'b0, 10'd1023, 1'b1, 8'h80, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_SET, 7'd0, 6'd0, 1'b1, 10'd0, 1'b1, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_READ, 7'd0, 6'd0, 1'b0, 10'd0, 1'b1, 8'h01, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_SET, 7'd0, 6'd0, 1'b0, 10'd0, 1'b1, 8'h00, STAT_DONE},
		// unused action code with every field at its top value
		'{ROW_ACTION, 8'd0, 8'd0, ACT_UNUSED, 7'd127, 6'd63, 1'b1, 10'd1023,
			1'b1, 8'h00, STAT_REJECT},
		// small panel: one page of eight bytes, clear touches only those
		'{ROW_PANEL, 8'd8, 8'd8, ACT_SET, 7'd0, 6'd0, 1'b0, 10'd0, 1'b0, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_CLEAR, 7'd0, 6'd0, 1'b0, 10'd0, 1'b1, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_READ, 7'd0, 6'd0, 1'b0, 10'd8, 1'b1, 8'h00, STAT_REJECT},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_SET, 7'd8, 6'd0, 1'b1, 10'd0, 1'b1, 8'h00, STAT_REJECT},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_SET, 7'd7, 6'd8, 1'b1, 10'd0, 1'b1, 8'h00, STAT_REJECT},
		// height 20 with the top data bit set: the partial third page is off the panel
		'{ROW_PANEL, 8'd100, 8'h94, ACT_SET, 7'd0, 6'd0, 1'b0, 10'd0, 1'b0, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_SET, 7'd99, 6'd15, 1'b1, 10'd0, 1'b0, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_SET, 7'd5, 6'd16, 1'b1, 10'd0, 1'b1, 8'h00, STAT_REJECT},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_READ, 7'd0, 6'd0, 1'b0, 10'd199, 1'b0, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_READ, 7'd0, 6'd0, 1'b0, 10'd200, 1'b1, 8'h00, STAT_REJECT},
		// widest panel: addresses past the store are refused
		'{ROW_PANEL, 8'd255, 8'd127, ACT_SET, 7'd0, 6'd0, 1'b0, 10'd0, 1'b0, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_SET, 7'd4, 6'd32, 1'b1, 10'd0, 1'b1, 8'h00, STAT_REJECT},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_SET, 7'd3, 6'd32, 1'b1, 10'd0, 1'b0, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_READ, 7'd0, 6'd0, 1'b0, 10'd1023, 1'b0, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_SET, 7'd127, 6'd63, 1'b1, 10'd0, 1'b1, 8'h00, STAT_REJECT},
		// zero width and a height under one page: nothing is in range, clear still done
		'{ROW_PANEL, 8'd0, 8'd7, ACT_SET, 7'd0, 6'd0, 1'b0, 10'd0, 1'b0, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_CLEAR, 7'd0, 6'd0, 1'b0, 10'd0, 1'b1, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_SET, 7'd0, 6'd0, 1'b1, 10'd0, 1'b1, 8'h00, STAT_REJECT},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_READ, 7'd0, 6'd0, 1'b0, 10'd0, 1'b1, 8'h00, STAT_REJECT},
		// back to full size: bytes outside earlier clears kept their bits
		'{ROW_PANEL, 8'd128, 8'd64, ACT_SET, 7'd0, 6'd0, 1'b0, 10'd0, 1'b0, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_READ, 7'd0, 6'd0, 1'b0, 10'd1023, 1'b0, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_CLEAR, 7'd0, 6'd0, 1'b0, 10'd0, 1'b1, 8'h00, STAT_DONE},
		'{ROW_ACTION, 8'd0, 8'd0, ACT_READ, 7'd0, 6'd0, 1'b0, 10'd1023, 1'b1, 8'h00, STAT_DONE}
	};

	// clock, reset and dut ports; every input starts at a known value
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pmfb_pkg::CFG_IDX_W-1:0] cfg_index = REG_PANEL_WIDTH;
	logic [pmfb_pkg::PANEL_W_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = ACT_SET;
	logic [6:0] pix_x = '0;
	logic [5:0] pix_y = '0;
	logic pix_on = 1'b0;
	logic [9:0] byte_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [pmfb_pkg::PIX_BITS-1:0] read_data;
	logic status;

	// predictor state: shadow copy of the frame store and panel size
	logic [7:0] shadow_frame [STORE_BYTES];
	int unsigned shadow_width = 128;
	int unsigned shadow_height = 64;

	panel_result_t awaited_results [$];   // oldest expected result at the front
	panel_result_t oldest_awaited;
	int mismatch_count = 0;

	// stimulus-to-receiver controls
	logic idle_free = 1'b0;          // neither side idles while set
	logic hold_off_request = 1'b0;
	logic hold_off_done = 1'b0;
	int hold_left = 0;

	page_mono_framebuffer_unit #(
		.STORE_BYTES(STORE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.pix_x(pix_x),
		.pix_y(pix_y),
		.pix_on(pix_on),
		.byte_index(byte_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// bytes covered by the panel: width times whole pages, capped at the store size
	function automatic int unsigned bytes_in_use();
		int unsigned n;
		n = shadow_width * (shadow_height / PAGE_ROWS);
		if (n > STORE_BYTES)
			n = STORE_BYTES;
		return n;
	endfunction

	// applies one action to the shadow frame and returns what the block should answer
	function automatic panel_result_t predict_framebuffer_action(input logic [1:0] act,
			input logic [6:0] x, input logic [5:0] y, input logic on, input logic [9:0] idx);
		panel_result_t res;
		int unsigned xi, yi, rows, addr, used;
		logic [7:0] mask;
		res.read_data = '0;
		res.status = STAT_DONE;
		xi = x;
		yi = y;
		case (act)
			ACT_SET: begin
				rows = (shadow_height / PAGE_ROWS) * PAGE_ROWS;
				addr = xi + (yi / PAGE_ROWS) * shadow_width;
				if (xi >= shadow_width || yi >= rows || addr >= STORE_BYTES) begin
					res.status = STAT_REJECT;
				end else begin
					mask = 8'h01 << y[2:0];
					if (on)
						shadow_frame[addr] = shadow_frame[addr] | mask;
					else
						shadow_frame[addr] = shadow_frame[addr] & ~mask;
				end
			end
			ACT_CLEAR: begin
				// only the panel's bytes; anything above keeps its contents
				used = bytes_in_use();
				for (int i = 0; i < used; i++)
					shadow_frame[i] = '0;
			end
			ACT_READ: begin
				if (idx < bytes_in_use())
					res.read_data = shadow_frame[idx];
				else
					res.status = STAT_REJECT;
			end
			default: res.status = STAT_REJECT;
		endcase
		return res;
	endfunction

	function automatic void flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t ns: %s", $time, msg);
	endfunction

	// result side: every transfer is matched against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result: read_data %02h status %0d",
					read_data, status));
			end else begin
				oldest_awaited = awaited_results.pop_front();
				if (read_data !== oldest_awaited.read_data)
					flag_mismatch($sformatf("read_data: expected %02h, got %02h",
						oldest_awaited.read_data, read_data));
				if (status !== oldest_awaited.status)
					flag_mismatch($sformatf("status: expected %0d, got %0d",
						oldest_awaited.status, status));
			end
		end
	end

	// receiver: random stalls, one long hold-off on request, none while idle_free
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_off_request && !hold_off_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_OFF_CYCLES;
			hold_off_done <= 1'b1;
		end else begin
			out_ready <= idle_free || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// offer one action and wait for its transfer; valid stays up if the next
	// action follows straight away
	task automatic offer_action(input logic [1:0] act, input logic [6:0] x,
			input logic [5:0] y, input logic on, input logic [9:0] idx,
			input logic known, input panel_result_t known_res);
		panel_result_t predicted;
		if (!idle_free) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		action <= act;
		pix_x <= x;
		pix_y <= y;
		pix_on <= on;
		byte_index <= idx;
		do @(posedge clk); while (!in_ready);
		// the predictor runs even when the row carries its own answer, to keep the shadow current
		predicted = predict_framebuffer_action(act, x, y, on, idx);
		awaited_results.push_back(known ? known_res : predicted);
	endtask

	// let every outstanding result come back, then wait out the DRAIN_GAP quiet spell
	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// panel size changes only with the block idle; width first, then height
	task automatic write_panel_size(input logic [7:0] width_data, input logic [7:0] height_data);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= REG_PANEL_WIDTH;
		cfg_data <= width_data;
		do @(posedge clk); while (!cfg_ready);
		shadow_width = width_data;
		cfg_index <= REG_PANEL_HEIGHT;
		cfg_data <= height_data;
		do @(posedge clk); while (!cfg_ready);
		shadow_height = height_data[6:0];
		cfg_valid <= 1'b0;
	endtask

	// mostly in-panel pixel updates and readbacks, with clears, stray codes and raw noise
	task automatic run_random_phase(input int n_items, input logic with_hold_off);
		int unsigned used, span_x, span_y, pick;
		logic [1:0] act;
		logic [6:0] x;
		logic [5:0] y;
		logic on;
		logic [9:0] idx;
		for (int k = 0; k < n_items; k++) begin
			used = bytes_in_use();
			span_x = (shadow_width > 128) ? 128 : shadow_width;
			span_y = (shadow_height / PAGE_ROWS) * PAGE_ROWS;
			if (span_y > 64)
				span_y = 64;
			pick = $urandom_range(99);
			act = 2'($urandom_range(3));
			x = 7'($urandom);
			y = 6'($urandom);
			on = 1'($urandom);
			idx = 10'($urandom);
			if (pick < 45 && span_x != 0 && span_y != 0) begin
				act = ACT_SET;
				x = 7'($urandom_range(span_x - 1));
				y = 6'($urandom_range(span_y - 1));
			end else if (pick < 85 && used != 0) begin
				act = ACT_READ;
				idx = 10'($urandom_range(used - 1));
			end else if (pick < 87) begin
				act = ACT_CLEAR;
			end else if (pick < 90) begin
				act = ACT_UNUSED;
			end
			// sender keeps offering through the hold-off so the block backs up
			if (with_hold_off && k == 30)
				hold_off_request <= 1'b1;
			offer_action(act, x, y, on, idx, 1'b0, '0);
		end
	endtask

	// main sequence
	initial begin
		panel_result_t row_res;
		logic [7:0] width_data;
		logic [6:0] height_rows;
		logic [0:0] height_pad;
		int wait_cycles;

		foreach (shadow_frame[i])
			shadow_frame[i] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed table; in_ready stays low through the post-reset sweep
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_PANEL) begin
				write_panel_size(DIRECTED[r].width_data, DIRECTED[r].height_data);
			end else begin
				row_res.read_data = DIRECTED[r].exp_data;
				row_res.status = DIRECTED[r].exp_status;
				offer_action(DIRECTED[r].act, DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].on,
					DIRECTED[r].idx, DIRECTED[r].known, row_res);
			end
		end

		// random phases, each preceded by a panel size write
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					width_data = 8'd128;
					height_rows = 7'd64;
				end
				1: begin
					width_data = 8'd255;
					height_rows = 7'd127;
				end
				2: begin
					width_data = 8'd1;
					height_rows = 7'd8;
				end
				3: begin
					width_data = 8'($urandom_range(255, 1));
					height_rows = 7'($urandom_range(127, 8));
				end
				4: begin
					width_data = 8'($urandom_range(255, 1));
					height_rows = 7'd0;
				end
				5: begin
					width_data = 8'd64;
					height_rows = 7'd63;
				end
				6: begin
					width_data = 8'($urandom_range(255));
					height_rows = 7'($urandom_range(127));
				end
				default: begin
					width_data = 8'd128;
					height_rows = 7'd64;
				end
			endcase
			// the unused top data bit of the height write is randomized too
			height_pad = 1'($urandom);
			write_panel_size(width_data, {height_pad, height_rows});
			idle_free <= (p == 2);
			run_random_phase((p == 4) ? 40 : 160, p == 1);
		end

		// wait out the tail, bounded, then look for stray transfers
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (awaited_results.size() != 0 && wait_cycles < END_WAIT_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatch_count += awaited_results.size();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// hang guard
	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule
